// ===== sv/urcr_pkg.sv =====
// Shared types and constants for the ultrasonic range change reporter.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package urcr_pkg;

    // Default echo counter width
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field and register widths
    localparam int DIST_W   = 16;
    localparam int SETTLE_W = 8;
    localparam int TRIG_W   = 8;
    localparam int SCALE_W  = 16;
    localparam int THR_W    = 16;
    localparam int IVL_W    = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd4;

    // Reset values of the configuration registers
    localparam logic [SETTLE_W-1:0] SETTLE_RST   = 8'd3;
    localparam logic [TRIG_W-1:0]   TRIGGER_RST  = 8'd10;
    localparam logic [SCALE_W-1:0]  SCALE_RST    = 16'd11239;
    localparam logic [THR_W-1:0]    THR_RST      = 16'd30;
    localparam logic [IVL_W-1:0]    INTERVAL_RST = 26'd5000000;

    // Minimum trigger pulse width in ticks
    localparam logic [TRIG_W-1:0] TRIG_MIN = 8'd2;

    // Per-item control from the phase sequencer
    typedef struct packed {
        logic trig;   // trigger pin level this tick
        logic done;   // measurement ended this tick
        logic sat;    // echo count sits at its limit
    } t_seq_ctl;

endpackage

`default_nettype wire

// ===== sv/urcr_if.sv =====
// Handshake channels of the range change reporter: echo input, result output,
// configuration write. Depends on urcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface urcr_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

interface urcr_out_if
    import urcr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              trigger_level;
    logic              report_valid;
    logic [DIST_W-1:0] distance_tenths;
    logic              is_initial;
    logic              echo_saturated;

    modport source (output valid, output trigger_level, output report_valid,
                    output distance_tenths, output is_initial, output echo_saturated,
                    input ready);
    modport sink   (input valid, input trigger_level, input report_valid,
                    input distance_tenths, input is_initial, input echo_saturated,
                    output ready);
endinterface

interface urcr_cfg_if
    import urcr_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/urcr_seq.sv =====
// Phase sequencer: settle, trigger pulse, echo wait, echo count, interval.
// Advances one tick per step. Depends on urcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urcr_seq
    import urcr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic                   i_echo_level,
    input  wire logic [SETTLE_W-1:0]    i_settle,
    input  wire logic [TRIG_W-1:0]      i_trig_w,
    input  wire logic [IVL_W-1:0]       i_interval,
    output t_seq_ctl                    o_ctl,
    output logic      [COUNT_WIDTH-1:0] o_count
);

    localparam logic [2:0] PH_SETTLE   = 3'd0;
    localparam logic [2:0] PH_TRIGGER  = 3'd1;
    localparam logic [2:0] PH_WAIT     = 3'd2;
    localparam logic [2:0] PH_COUNT    = 3'd3;
    localparam logic [2:0] PH_INTERVAL = 3'd4;

    localparam logic [COUNT_WIDTH-1:0] LIMIT = '1;

    logic [2:0]             r_phase, n_phase;
    logic [IVL_W-1:0]       r_cnt,   n_cnt;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [IVL_W-1:0]       cnt_inc;
    logic [TRIG_W-1:0]      width;

    assign cnt_inc = r_cnt + 1'b1;
    assign width   = (i_trig_w < TRIG_MIN) ? TRIG_MIN : i_trig_w;
    assign o_count = r_count;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_count = r_count;
        o_ctl   = '0;
        case (r_phase)
            PH_TRIGGER: begin
                o_ctl.trig = 1'b1;
                n_cnt      = cnt_inc;
                if (cnt_inc >= {{(IVL_W-TRIG_W){1'b0}}, width}) begin
                    n_phase = PH_WAIT;
                    n_cnt   = '0;
                end
            end
            PH_WAIT: begin
                if (i_echo_level) begin
                    n_count = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (i_echo_level) begin
                    if (r_count != LIMIT) begin
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    o_ctl.done = 1'b1;
                    o_ctl.sat  = (r_count == LIMIT);
                    n_cnt      = '0;
                    n_phase    = (i_interval == '0) ? PH_SETTLE : PH_INTERVAL;
                end
            end
            PH_INTERVAL: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= i_interval) begin
                    n_phase = PH_SETTLE;
                    n_cnt   = '0;
                end
            end
            default: begin
                // settle; also catches unused codes
                n_cnt = cnt_inc;
                if (cnt_inc >= {{(IVL_W-SETTLE_W){1'b0}}, i_settle}) begin
                    n_phase = PH_TRIGGER;
                    n_cnt   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SETTLE;
            r_cnt   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ultrasonic_range_change_reporter_unit.sv =====
// A tick item passes through the input, sequencer, multiply and output registers in that order.
// Throughput: one tick item per cycle; each stage holds only while the stage after it is full.
// Reset (i_rst_n low, synchronous): pipeline emptied, sequencer back to settle,
// configuration registers to defaults, report history cleared.
// Depends on urcr_pkg, urcr_if (channels) and urcr_seq (phase sequencer).
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_range_change_reporter_unit
    import urcr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    urcr_in_if.sink    i_echo,
    urcr_out_if.source o_rpt,
    urcr_cfg_if.sink   i_cfg
);

    // Product of echo count and Q16 scale, its rounded sum, and the rounded
    // value widened so the overflow test has a fixed top slice.
    localparam int PROD_W = COUNT_WIDTH + SCALE_W;
    localparam int RND_W  = PROD_W + 1 - 16;
    localparam int EXT_W  = RND_W + DIST_W;

    // ---------------- configuration registers ----------------
    logic [SETTLE_W-1:0] r_settle;
    logic [TRIG_W-1:0]   r_trig_w;
    logic [SCALE_W-1:0]  r_scale;
    logic [THR_W-1:0]    r_thr;
    logic [IVL_W-1:0]    r_interval;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle   <= SETTLE_RST;
            r_trig_w   <= TRIGGER_RST;
            r_scale    <= SCALE_RST;
            r_thr      <= THR_RST;
            r_interval <= INTERVAL_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SETTLE:    r_settle   <= i_cfg.data[SETTLE_W-1:0];
                CFG_TRIGGER:   r_trig_w   <= i_cfg.data[TRIG_W-1:0];
                CFG_SCALE:     r_scale    <= i_cfg.data[SCALE_W-1:0];
                CFG_THRESHOLD: r_thr      <= i_cfg.data[THR_W-1:0];
                CFG_INTERVAL:  r_interval <= i_cfg.data[IVL_W-1:0];
                default: ;     // unknown index: dropped
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    // Each stage loads when it is empty or its content moves on.
    logic r_v1, r_v2, r_v3, r_vo;
    logic rdy_o, rdy_3, rdy_2, rdy_1;

    assign rdy_o = !r_vo || o_rpt.ready;
    assign rdy_3 = !r_v3 || rdy_o;
    assign rdy_2 = !r_v2 || rdy_3;
    assign rdy_1 = !r_v1 || rdy_2;

    assign i_echo.ready = rdy_1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy_1) r_v1 <= i_echo.valid;
            if (rdy_2) r_v2 <= r_v1;
            if (rdy_3) r_v3 <= r_v2;
            if (rdy_o) r_vo <= r_v3;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic r1_echo;

    always_ff @(posedge i_clk) begin
        if (rdy_1) r1_echo <= i_echo.echo_level;
    end

    // ---------------- stage 2: phase sequencer ----------------
    // The sequencer steps once per item, as the item leaves stage 1.
    t_seq_ctl               seq_ctl;
    logic [COUNT_WIDTH-1:0] seq_count;
    t_seq_ctl               r2_ctl;
    logic [COUNT_WIDTH-1:0] r2_count;

    urcr_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (r_v1 && rdy_2),
        .i_echo_level (r1_echo),
        .i_settle     (r_settle),
        .i_trig_w     (r_trig_w),
        .i_interval   (r_interval),
        .o_ctl        (seq_ctl),
        .o_count      (seq_count)
    );

    always_ff @(posedge i_clk) begin
        if (rdy_2) begin
            r2_ctl   <= seq_ctl;
            r2_count <= seq_count;
        end
    end

    // ---------------- stage 3: scale multiply ----------------
    t_seq_ctl          r3_ctl;
    logic [PROD_W-1:0] r3_prod;

    always_ff @(posedge i_clk) begin
        if (rdy_3) begin
            r3_ctl  <= r2_ctl;
            r3_prod <= PROD_W'(r2_count * r_scale);
        end
    end

    // ---------------- output stage: round, compare, report ----------------
    // Measurement ends are at least five ticks apart, so the history below is
    // always up to date when the next end reaches this stage.
    logic [PROD_W:0]   rnd_sum;
    logic [EXT_W-1:0]  rnd_ext;
    logic [DIST_W-1:0] dist_val;
    logic [DIST_W-1:0] diff;
    logic              report;
    logic [DIST_W-1:0] r_last;
    logic              r_have;

    // round half up, saturate to 16 bits
    assign rnd_sum  = {1'b0, r3_prod} + (PROD_W+1)'(32768);
    assign rnd_ext  = {{DIST_W{1'b0}}, rnd_sum[PROD_W:16]};
    assign dist_val = (|rnd_ext[EXT_W-1:DIST_W]) ? '1 : rnd_ext[DIST_W-1:0];
    assign diff     = (dist_val > r_last) ? (dist_val - r_last) : (r_last - dist_val);
    assign report   = r3_ctl.done && (!r_have || (diff > r_thr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_have <= 1'b0;
        end else if (r_v3 && rdy_o && report) begin
            r_last <= dist_val;
            r_have <= 1'b1;
        end
    end

    logic              r_o_trig;
    logic              r_o_rep;
    logic [DIST_W-1:0] r_o_dist;
    logic              r_o_init;
    logic              r_o_sat;

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_o_trig <= r3_ctl.trig;
            r_o_rep  <= report;
            r_o_dist <= report ? dist_val : '0;
            r_o_init <= report && !r_have;
            r_o_sat  <= report && r3_ctl.sat;
        end
    end

    assign o_rpt.valid           = r_vo;
    assign o_rpt.trigger_level   = r_o_trig;
    assign o_rpt.report_valid    = r_o_rep;
    assign o_rpt.distance_tenths = r_o_dist;
    assign o_rpt.is_initial      = r_o_init;
    assign o_rpt.echo_saturated  = r_o_sat;

endmodule

`default_nettype wire

// ===== sv/urcr_checker.sv =====
// Port-level checks on the result channel of the range change reporter,
// bound to the top level. Depends on urcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urcr_checker
    import urcr_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              i_ready,
    input wire logic              i_trig,
    input wire logic              i_rep,
    input wire logic [DIST_W-1:0] i_dist,
    input wire logic              i_init,
    input wire logic              i_sat
);

    // set once the first measurement has gone out
    logic r_seen_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_init <= 1'b0;
        end else if (i_valid && i_ready && i_init) begin
            r_seen_init <= 1'b1;
        end
    end

    // no report: all result fields zero
    a_quiet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_rep) |-> (i_dist == '0 && !i_init && !i_sat))
        else $error("result fields set without a report");

    // trigger is low on a tick that carries a report
    a_trig_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_trig && i_rep))
        else $error("report on a trigger-high tick");

    // only one initial report after reset
    a_one_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_seen_init) |-> !i_init)
        else $error("second initial report");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_dist) && $stable(i_rep)))
        else $error("stalled result changed");

endmodule

bind ultrasonic_range_change_reporter_unit urcr_checker u_urcr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rpt.valid),
    .i_ready (o_rpt.ready),
    .i_trig  (o_rpt.trigger_level),
    .i_rep   (o_rpt.report_valid),
    .i_dist  (o_rpt.distance_tenths),
    .i_init  (o_rpt.is_initial),
    .i_sat   (o_rpt.echo_saturated)
);

`default_nettype wire

// ===== verif/urcr_range_checker.sv =====
// Scoreboard for the range change reporter: watches the echo, result and config channels,
// predicts one result per accepted tick item and compares it field by field.
// Depends on urcr_pkg.
`timescale 1ns / 1ps

module urcr_range_checker
    import urcr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_echo_valid,
    input  logic                  i_echo_ready,
    input  logic                  i_echo_level,
    input  logic                  i_rpt_valid,
    input  logic                  i_rpt_ready,
    input  logic                  i_trigger_level,
    input  logic                  i_report_valid,
    input  logic [DIST_W-1:0]     i_distance_tenths,
    input  logic                  i_is_initial,
    input  logic                  i_echo_saturated,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_err_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_reports,
    output int                    o_saturated
);

    localparam logic [COUNT_WIDTH-1:0] ECHO_LIMIT = '1;

    typedef enum logic [2:0] {
        SEQ_SETTLE   = 3'd0,
        SEQ_TRIGGER  = 3'd1,
        SEQ_WAIT     = 3'd2,
        SEQ_COUNT    = 3'd3,
        SEQ_INTERVAL = 3'd4
    } t_seq_phase;

    typedef struct packed {
        logic              trig;
        logic              rpt;
        logic [DIST_W-1:0] tenths;
        logic              init;
        logic              sat;
    } t_tick_result;

    // register copies
    logic [SETTLE_W-1:0] settle_len;
    logic [TRIG_W-1:0]   trig_len;
    logic [SCALE_W-1:0]  scale;
    logic [THR_W-1:0]    thr;
    logic [IVL_W-1:0]    ivl_len;

    // sequencer copy
    t_seq_phase             seq_phase;
    logic [31:0]            tick_cnt;
    logic [COUNT_WIDTH-1:0] echo_ticks;
    logic [DIST_W-1:0]      last_dist;
    logic                   have_dist;

    t_tick_result expected_q[$];
    t_tick_result want_r;
    t_tick_result got_r;
    int           err_total;
    int           checked_total;
    int           report_total;
    int           sat_total;

    function automatic logic [DIST_W-1:0] tenths_of(input logic [COUNT_WIDTH-1:0] cnt,
                                                    input logic [SCALE_W-1:0] sc);
        logic [63:0] v;
        v = (64'(cnt) * 64'(sc) + 64'd32768) >> 16;
        return (v > 64'd65535) ? '1 : v[DIST_W-1:0];
    endfunction

    task automatic reset_model();
        settle_len = SETTLE_RST;
        trig_len   = TRIGGER_RST;
        scale      = SCALE_RST;
        thr        = THR_RST;
        ivl_len    = INTERVAL_RST;
        seq_phase  = SEQ_SETTLE;
        tick_cnt   = '0;
        echo_ticks = '0;
        last_dist  = '0;
        have_dist  = 1'b0;
    endtask

    // One tick of the ranging sequence.
    task automatic predict_tick(input logic echo, output t_tick_result r);
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] diff;
        r = '0;
        case (seq_phase)
            SEQ_TRIGGER: begin
                r.trig = 1'b1;
                tick_cnt++;
                if (tick_cnt >= ((trig_len < TRIG_MIN) ? TRIG_MIN : trig_len)) begin
                    seq_phase = SEQ_WAIT;
                    tick_cnt  = '0;
                end
            end
            SEQ_WAIT: begin
                if (echo) begin
                    echo_ticks = COUNT_WIDTH'(1);
                    seq_phase  = SEQ_COUNT;
                end
            end
            SEQ_COUNT: begin
                if (echo) begin
                    if (echo_ticks != ECHO_LIMIT)
                        echo_ticks++;
                end else begin
                    d    = tenths_of(echo_ticks, scale);
                    diff = (d > last_dist) ? d - last_dist : last_dist - d;
                    if (!have_dist || diff > thr) begin
                        r.rpt     = 1'b1;
                        r.tenths  = d;
                        r.init    = !have_dist;
                        r.sat     = (echo_ticks == ECHO_LIMIT);
                        last_dist = d;
                        have_dist = 1'b1;
                    end
                    tick_cnt  = '0;
                    seq_phase = (ivl_len == '0) ? SEQ_SETTLE : SEQ_INTERVAL;
                end
            end
            SEQ_INTERVAL: begin
                tick_cnt++;
                if (tick_cnt >= ivl_len) begin
                    seq_phase = SEQ_SETTLE;
                    tick_cnt  = '0;
                end
            end
            default: begin
                tick_cnt++;
                if (tick_cnt >= settle_len) begin
                    seq_phase = SEQ_TRIGGER;
                    tick_cnt  = '0;
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            err_total++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            expected_q.delete();
        end else begin
            if (i_rpt_valid && i_rpt_ready) begin
                got_r = '{i_trigger_level, i_report_valid, i_distance_tenths,
                          i_is_initial, i_echo_saturated};
                if (expected_q.size() == 0) begin
                    err_total++;
                    $display("%0t: result expected none, got distance %0d trigger %0b",
                             $time, got_r.tenths, got_r.trig);
                end else begin
                    want_r = expected_q.pop_front();
                    compare_field("trigger_level", want_r.trig, got_r.trig);
                    compare_field("report_valid", want_r.rpt, got_r.rpt);
                    compare_field("distance_tenths", want_r.tenths, got_r.tenths);
                    compare_field("is_initial", want_r.init, got_r.init);
                    compare_field("echo_saturated", want_r.sat, got_r.sat);
                    checked_total++;
                    if (got_r.rpt)
                        report_total++;
                    if (got_r.rpt && got_r.sat)
                        sat_total++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SETTLE:    settle_len = i_cfg_data[SETTLE_W-1:0];
                    CFG_TRIGGER:   trig_len   = i_cfg_data[TRIG_W-1:0];
                    CFG_SCALE:     scale      = i_cfg_data[SCALE_W-1:0];
                    CFG_THRESHOLD: thr        = i_cfg_data[THR_W-1:0];
                    CFG_INTERVAL:  ivl_len    = i_cfg_data[IVL_W-1:0];
                    default: ;
                endcase
            end
            if (i_echo_valid && i_echo_ready) begin
                predict_tick(i_echo_level, want_r);
                expected_q.push_back(want_r);
            end
        end
        o_err_count <= err_total;
        o_pending   <= expected_q.size();
        o_checked   <= checked_total;
        o_reports   <= report_total;
        o_saturated <= sat_total;
    end

    initial begin
        err_total     = 0;
        checked_total = 0;
        report_total  = 0;
        sat_total     = 0;
        reset_model();
    end

endmodule

// ===== verif/ultrasonic_range_change_reporter_unit_tb.sv =====
// Top of the range change reporter testbench: clock, reset, echo tick stimulus,
// register programming and the verdict. Depends on urcr_pkg, urcr_if,
// urcr_range_checker and the block itself.
`timescale 1ns / 1ps

module ultrasonic_range_change_reporter_unit_tb;
    import urcr_pkg::*;

    localparam int COUNT_WIDTH  = COUNT_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 3_000_000;
    // one long echo, well past the usual bursts
    localparam int LONG_RUN     = 400;
    localparam logic [IVL_W-1:0]     IVL_MAX            = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = CFG_INTERVAL + 3'd1;

    logic i_clk;
    logic i_rst_n;

    urcr_in_if  echo_ch ();
    urcr_out_if rpt_ch ();
    urcr_cfg_if cfg_ch ();

    int  err_count;
    int  pending;
    int  checked;
    int  reports;
    int  saturated;
    int  sent_items;
    int  long_items;
    int  cycle_cnt;
    int  sink_hold;
    // when set, neither side inserts gaps or stalls
    bit  calm;

    ultrasonic_range_change_reporter_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_echo  (echo_ch),
        .o_rpt   (rpt_ch),
        .i_cfg   (cfg_ch)
    );

    urcr_range_checker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_echo_valid      (echo_ch.valid),
        .i_echo_ready      (echo_ch.ready),
        .i_echo_level      (echo_ch.echo_level),
        .i_rpt_valid       (rpt_ch.valid),
        .i_rpt_ready       (rpt_ch.ready),
        .i_trigger_level   (rpt_ch.trigger_level),
        .i_report_valid    (rpt_ch.report_valid),
        .i_distance_tenths (rpt_ch.distance_tenths),
        .i_is_initial      (rpt_ch.is_initial),
        .i_echo_saturated  (rpt_ch.echo_saturated),
        .i_cfg_valid       (cfg_ch.valid),
        .i_cfg_ready       (cfg_ch.ready),
        .i_cfg_index       (cfg_ch.index),
        .i_cfg_data        (cfg_ch.data),
        .o_err_count       (err_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_reports         (reports),
        .o_saturated       (saturated)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_hold = 0;
            rpt_ch.ready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            rpt_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            sink_hold = pick_gap() - 1;
            rpt_ch.ready <= 1'b0;
        end else begin
            rpt_ch.ready <= 1'b1;
        end
    end

    // One tick item. valid stays high into the next call unless a gap is taken,
    // so it never gets two assignments in one step.
    task automatic send_tick(input logic lvl);
        int g;
        g = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (g > 0) begin
            echo_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        echo_ch.valid      <= 1'b1;
        echo_ch.echo_level <= lvl;
        @(posedge i_clk);
        while (!echo_ch.ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_tick(lvl);
    endtask

    // Low ticks to get through settle/trigger, then an echo of hi ticks, then the
    // falling tick that closes the measurement.
    task automatic echo_pulse(input int pre, input int hi);
        send_run(1'b0, pre);
        send_run(1'b1, hi);
        send_tick(1'b0);
    endtask

    // Stop sending and wait until every tick item has come back.
    task automatic drain_results();
        echo_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // cfg valid is left high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // Full register set, written only once the block has gone quiet. A stray write
    // to an unmapped index goes last so a decode slip would corrupt a live register.
    task automatic load_config(input logic [SETTLE_W-1:0] s, input logic [TRIG_W-1:0] t,
                               input logic [SCALE_W-1:0] sc, input logic [THR_W-1:0] th,
                               input logic [IVL_W-1:0] iv, input bit stray);
        drain_results();
        write_reg(CFG_SETTLE, CFG_DATA_W'(s));
        write_reg(CFG_TRIGGER, CFG_DATA_W'(t));
        write_reg(CFG_SCALE, CFG_DATA_W'(sc));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(th));
        write_reg(CFG_INTERVAL, CFG_DATA_W'(iv));
        if (stray)
            write_reg(CFG_FIRST_UNMAPPED + CFG_IDX_W'($urandom_range(0, 2)),
                      CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Random registers, then echo traffic: mostly clean low/high bursts of varied
    // length, the rest random noise bits.
    task automatic ranging_phase(input int budget, input bit slow_seq);
        logic [SETTLE_W-1:0] s;
        logic [TRIG_W-1:0]   t;
        logic [SCALE_W-1:0]  sc;
        logic [THR_W-1:0]    th;
        logic [IVL_W-1:0]    iv;
        int                  start;
        int                  lo;
        int                  hi;
        int                  r;
        case ($urandom_range(0, 5))
            0:       s = 8'd0;
            1:       s = 8'd1;
            default: s = SETTLE_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 5))
            0:       t = 8'd0;
            1:       t = 8'd1;
            2:       t = TRIG_MIN;
            default: t = TRIG_W'($urandom_range(2, 8));
        endcase
        if (slow_seq) begin
            s = '1;
            t = '1;
        end
        case ($urandom_range(0, 5))
            0:       sc = '0;
            1:       sc = '1;
            default: sc = SCALE_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       th = '0;
            1:       th = '1;
            2:       th = THR_W'($urandom);
            default: th = THR_W'($urandom_range(0, 20));
        endcase
        case ($urandom_range(0, 5))
            0:       iv = '0;
            1:       iv = IVL_W'($urandom_range(13, 200));
            default: iv = IVL_W'($urandom_range(0, 12));
        endcase
        load_config(s, t, sc, th, iv, $urandom_range(0, 3) == 0);
        start = sent_items;
        while (sent_items - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                r = $urandom_range(0, 99);
                lo = (r < 70) ? $urandom_range(1, 16) :
                     (r < 95) ? $urandom_range(17, 60) : $urandom_range(200, 600);
                r = $urandom_range(0, 99);
                hi = (r < 75) ? $urandom_range(1, 24) :
                     (r < 95) ? $urandom_range(25, 120) : $urandom_range(121, 400);
                echo_pulse(lo, hi);
            end else begin
                repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        calm       = 1'b0;
        sent_items = 0;
        long_items = 0;
        i_rst_n            <= 1'b0;
        echo_ch.valid      <= 1'b0;
        echo_ch.echo_level <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_SETTLE;
        cfg_ch.data        <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: first measurement is always reported and marked initial.
        // Afterwards the block sits in its reset-default interval, where echo is ignored.
        echo_pulse(13, 3);
        send_tick(1'b1);
        send_tick(1'b0);

        // Zero settle, short trigger, zero interval, zero threshold, full scale.
        // Rewriting the interval also cuts the pending long wait short.
        // A repeat of the same distance is not reported; the second pulse falls in the trigger and is not measured.
        load_config(8'd0, 8'd1, '1, '0, '0, 1'b1);
        echo_pulse(5, 1);
        echo_pulse(1, 2);

        // Zero scale against the largest threshold: distance 0, no report.
        load_config(8'd1, TRIG_MIN, '0, '1, '0, 1'b0);
        echo_pulse(4, 4);

        // One long echo without idling, then parked in the longest interval.
        load_config(8'd1, TRIG_MIN, '1, '0, IVL_MAX, 1'b0);
        calm = 1'b1;
        long_items = sent_items;
        echo_pulse(3, LONG_RUN);
        send_run(1'b0, 4);
        long_items = sent_items - long_items;
        calm = 1'b0;

        // Random part: longest settle and trigger first, then assorted settings,
        // one of them without any idling.
        ranging_phase(400, 1'b1);
        for (int i = 0; i < 6; i++) begin
            calm = (i == 3);
            ranging_phase(100, 1'b0);
        end
        calm = 1'b0;

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d tick items (%0d in the long echo run), %0d results checked",
                 sent_items, long_items, checked);
        $display("%0d distance reports, %0d of them with a saturated echo count",
                 reports, saturated);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
